@@ rtl/core/bll_pkg.sv @@
// Shared types and constants for the brick locator.
package bll_pkg;

    localparam int unsigned VOL_W   = 16;
    localparam int unsigned BRICK_W = 13;
    localparam int unsigned OVL_W   = 8;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned IDX_W   = 49;
    localparam int unsigned CFG_IW  = 3;

    localparam logic [CFG_IW-1:0] REG_VOLUME_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_VOLUME_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_VOLUME_DEPTH  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_BRICK_WIDTH   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_BRICK_HEIGHT  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_BRICK_DEPTH   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_OVERLAP       = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_INIT,
        ST_B_DIV_GO,
        ST_B_DIV_WAIT,
        ST_B_MUL1,
        ST_B_MUL2,
        ST_B_WRITE,
        ST_Q_READ,
        ST_Q_CHECK,
        ST_Q_MUL2,
        ST_Q_SUM
    } state_t;

    // One level of the table: remainder and count per axis, count_x*count_y,
    // and the first linear brick index of the level.
    typedef struct packed {
        logic [2:0][BRICK_W-1:0] rem;
        logic [2:0][CNT_W-1:0]   cnt;
        logic [31:0]             cxcy;
        logic [IDX_W-1:0]        first;
    } entry_t;

    typedef enum logic [1:0] {
        MUL_CNT_XY,
        MUL_VOLUME,
        MUL_Q_Y,
        MUL_Q_Z
    } mul_sel_t;

endpackage

@@ rtl/core/bll_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bll_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bll_div.sv @@
// Restoring divider, one quotient bit per cycle: brick count and remainder.
module bll_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bll_pkg::VOL_W-1:0]    dividend,
    input  logic [bll_pkg::BRICK_W-1:0]  divisor,
    output logic                         done,
    output logic [bll_pkg::VOL_W-1:0]    quot,
    output logic [bll_pkg::BRICK_W-1:0]  rem
);

    import bll_pkg::*;

    logic [VOL_W-1:0]   quo_reg;
    logic [BRICK_W-1:0] rem_reg;
    logic [3:0]         step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [BRICK_W:0]   trial;
    logic               fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[VOL_W-1]};
        fits  = trial >= {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 4'd1;
            if (step_reg == 4'd15)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, subtract when it fits
            if (fits)
            begin
                rem_reg <= BRICK_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_reg <= trial[BRICK_W-1:0];
            end
            quo_reg <= {quo_reg[VOL_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/core/bricked_lod_brick_locator.sv @@
// Brick locator: level table build on demand and brick queries.
// With a current table a query runs ST_Q_READ, ST_Q_CHECK, ST_Q_MUL2 and ST_Q_SUM after
// accept; ST_Q_SUM waits for a free output register. After reset or a register write
// the first query rebuilds the table, running the serial divider once per axis per level.
// One item at a time; in_ready is high only in idle. Reset is asynchronous,
// active low, clears control state and loads the register defaults.
module bricked_lod_brick_locator #(
    parameter int unsigned MAX_LEVELS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bll_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [15:0]                   brick_x,
    input  logic [15:0]                   brick_y,
    input  logic [15:0]                   brick_z,
    input  logic [4:0]                    level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [48:0]                   brick_index,
    output logic [12:0]                   size_x,
    output logic [12:0]                   size_y,
    output logic [12:0]                   size_z,
    output logic                          last_in_x,
    output logic                          last_in_y,
    output logic                          last_in_z,
    output logic [5:0]                    levels_present,
    output logic [48:0]                   total_bricks,
    output logic                          bad_request
);

    import bll_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_LEVELS);
    localparam int unsigned LCW = $clog2(MAX_LEVELS + 1);

    state_t state_reg, state_next;

    // configuration
    logic [VOL_W-1:0]   vol_reg   [3];
    logic [BRICK_W-1:0] bsz_reg   [3];
    logic [OVL_W-1:0]   ovl_reg;
    logic               table_ready_reg;
    logic [LCW-1:0]     level_total_reg;
    logic [IDX_W-1:0]   sum_reg;

    // build
    logic [VOL_W-1:0]   vs_reg    [3];
    logic [BRICK_W-1:0] u_reg     [3];
    logic [CNT_W-1:0]   cnt_reg   [3];
    logic [BRICK_W-1:0] rem_reg   [3];
    logic [31:0]        cxcy_reg;
    logic [47:0]        prod_reg;
    logic [IDX_W-1:0]   first_reg;
    logic [1:0]         axis_reg;
    logic [LCW-1:0]     n_reg;

    // query
    logic [15:0]        coord_reg [3];
    logic [4:0]         lvl_reg;
    logic [IDX_W-1:0]   acc_reg;
    logic               bad_reg;

    // output beat
    logic               out_valid_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [BRICK_W-1:0] size_reg  [3];
    logic [2:0]         last_reg;
    logic [5:0]         present_reg;
    logic [IDX_W-1:0]   total_reg;
    logic               bad_out_reg;

    // control
    logic     ram_re;
    logic     ram_we;
    logic     div_start;
    mul_sel_t mul_sel;
    logic     usable_ok;
    logic     more;
    logic     build_end;
    logic     out_free;

    entry_t             wentry;
    entry_t             rentry;
    logic               div_done;
    logic [VOL_W-1:0]   div_quot;
    logic [BRICK_W-1:0] div_rem;

    logic [31:0]        mul_a;
    logic [15:0]        mul_b;
    logic [47:0]        mul_p;

    logic [OVL_W:0]     ovl2;
    logic               last_c    [3];
    logic [BRICK_W-1:0] size_c    [3];
    logic               bad_c;

    assign ovl2 = {ovl_reg, 1'b0};

    always_comb
    begin
        usable_ok = 1'b1;
        more      = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (bsz_reg[a] <= {{(BRICK_W-OVL_W-1){1'b0}}, ovl2})
            begin
                usable_ok = 1'b0;
            end
            if (vs_reg[a] > {{(VOL_W-BRICK_W){1'b0}}, u_reg[a]})
            begin
                more = 1'b1;
            end
        end
        build_end = !more || (n_reg + 1'b1 == LCW'(MAX_LEVELS));
        out_free  = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = table_ready_reg ? ST_Q_READ : ST_B_INIT;
                end
            end
            ST_B_INIT:     state_next = usable_ok ? ST_B_DIV_GO : ST_Q_READ;
            ST_B_DIV_GO:   state_next = ST_B_DIV_WAIT;
            ST_B_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (axis_reg == 2'd2) ? ST_B_MUL1 : ST_B_DIV_GO;
                end
            end
            ST_B_MUL1:     state_next = ST_B_MUL2;
            ST_B_MUL2:     state_next = ST_B_WRITE;
            ST_B_WRITE:    state_next = build_end ? ST_Q_READ : ST_B_DIV_GO;
            ST_Q_READ:     state_next = ST_Q_CHECK;
            ST_Q_CHECK:    state_next = ST_Q_MUL2;
            ST_Q_MUL2:     state_next = ST_Q_SUM;
            ST_Q_SUM:      state_next = out_free ? ST_IDLE : ST_Q_SUM;
            default:       state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        mul_sel   = MUL_CNT_XY;
        unique case (state_reg)
            ST_IDLE:       in_ready = 1'b1;
            ST_B_DIV_GO:   div_start = 1'b1;
            ST_B_MUL2:     mul_sel = MUL_VOLUME;
            ST_B_WRITE:    ram_we = 1'b1;
            ST_Q_READ:     ram_re = 1'b1;
            ST_Q_CHECK:    mul_sel = MUL_Q_Y;
            ST_Q_MUL2:     mul_sel = MUL_Q_Z;
            default:       mul_sel = MUL_CNT_XY;
        endcase
    end

    // shared multiplier
    always_comb
    begin
        case (mul_sel)
            MUL_CNT_XY:
            begin
                mul_a = {16'b0, cnt_reg[0]};
                mul_b = cnt_reg[1];
            end
            MUL_VOLUME:
            begin
                mul_a = cxcy_reg;
                mul_b = cnt_reg[2];
            end
            MUL_Q_Y:
            begin
                mul_a = {16'b0, rentry.cnt[0]};
                mul_b = coord_reg[1];
            end
            default:
            begin
                mul_a = rentry.cxcy;
                mul_b = coord_reg[2];
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            wentry.rem[a] = rem_reg[a];
            wentry.cnt[a] = cnt_reg[a];
        end
        wentry.cxcy  = cxcy_reg;
        wentry.first = first_reg;
    end

    // query checks and brick sizes from the read entry
    always_comb
    begin
        bad_c = {{LCW{1'b0}}, lvl_reg} >= {5'b0, level_total_reg};
        for (int a = 0; a < 3; a++)
        begin
            if ({1'b0, coord_reg[a]} >= {1'b0, rentry.cnt[a]})
            begin
                bad_c = 1'b1;
            end
            last_c[a] = ({1'b0, coord_reg[a]} + 17'd1) == {1'b0, rentry.cnt[a]};
            if (last_c[a] && (rentry.rem[a] != '0))
            begin
                size_c[a] = BRICK_W'({{(BRICK_W-OVL_W-1){1'b0}}, ovl2} + rentry.rem[a]);
            end
            else
            begin
                size_c[a] = bsz_reg[a];
            end
        end
    end

    bll_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (vs_reg[axis_reg]),
        .divisor  (u_reg[axis_reg]),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    bll_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_LEVELS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (n_reg[AW-1:0]),
        .wdata (wentry),
        .re    (ram_re),
        .raddr (AW'(lvl_reg)),
        .rdata (rentry)
    );

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            table_ready_reg <= 1'b0;
            level_total_reg <= '0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
            axis_reg        <= '0;
            n_reg           <= '0;
            for (int a = 0; a < 3; a++)
            begin
                vol_reg[a] <= VOL_W'(1);
                bsz_reg[a] <= BRICK_W'(64);
            end
            ovl_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VOLUME_WIDTH:  vol_reg[0] <= cfg_data;
                    REG_VOLUME_HEIGHT: vol_reg[1] <= cfg_data;
                    REG_VOLUME_DEPTH:  vol_reg[2] <= cfg_data;
                    REG_BRICK_WIDTH:   bsz_reg[0] <= cfg_data[BRICK_W-1:0];
                    REG_BRICK_HEIGHT:  bsz_reg[1] <= cfg_data[BRICK_W-1:0];
                    REG_BRICK_DEPTH:   bsz_reg[2] <= cfg_data[BRICK_W-1:0];
                    REG_OVERLAP:       ovl_reg <= cfg_data[OVL_W-1:0];
                    default:           ;
                endcase
                if (cfg_index <= REG_OVERLAP)
                begin
                    table_ready_reg <= 1'b0;
                end
            end

            case (state_reg)
                ST_B_INIT:
                begin
                    axis_reg <= '0;
                    n_reg    <= '0;
                    if (!usable_ok)
                    begin
                        table_ready_reg <= 1'b1;
                        level_total_reg <= '0;
                        sum_reg         <= '0;
                    end
                end
                ST_B_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    end
                end
                ST_B_WRITE:
                begin
                    n_reg <= n_reg + 1'b1;
                    if (build_end)
                    begin
                        table_ready_reg <= 1'b1;
                        level_total_reg <= n_reg + 1'b1;
                        sum_reg         <= first_reg + IDX_W'(prod_reg);
                    end
                end
                default: ;
            endcase

            if (state_reg == ST_Q_SUM && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    coord_reg[0] <= brick_x;
                    coord_reg[1] <= brick_y;
                    coord_reg[2] <= brick_z;
                    lvl_reg      <= level;
                end
            end
            ST_B_INIT:
            begin
                first_reg <= '0;
                for (int a = 0; a < 3; a++)
                begin
                    vs_reg[a] <= vol_reg[a];
                    u_reg[a]  <= BRICK_W'(bsz_reg[a] - {{(BRICK_W-OVL_W-1){1'b0}}, ovl2});
                end
            end
            ST_B_DIV_WAIT:
            begin
                if (div_done)
                begin
                    cnt_reg[axis_reg] <= div_quot + {15'b0, (div_rem != '0)};
                    rem_reg[axis_reg] <= div_rem;
                end
            end
            ST_B_MUL1:     cxcy_reg <= mul_p[31:0];
            ST_B_MUL2:     prod_reg <= mul_p;
            ST_B_WRITE:
            begin
                first_reg <= first_reg + IDX_W'(prod_reg);
                // halve every axis that still exceeds the usable size
                for (int a = 0; a < 3; a++)
                begin
                    if (vs_reg[a] > {{(VOL_W-BRICK_W){1'b0}}, u_reg[a]})
                    begin
                        vs_reg[a] <= VOL_W'(({1'b0, vs_reg[a]} + 17'd1) >> 1);
                    end
                end
            end
            ST_Q_CHECK:
            begin
                bad_reg  <= bad_c;
                acc_reg  <= rentry.first + IDX_W'(coord_reg[0]);
                prod_reg <= mul_p;
            end
            ST_Q_MUL2:
            begin
                acc_reg  <= acc_reg + IDX_W'(prod_reg);
                prod_reg <= mul_p;
            end
            ST_Q_SUM:
            begin
                if (out_free)
                begin
                    present_reg <= 6'(level_total_reg);
                    total_reg   <= sum_reg;
                    bad_out_reg <= bad_reg;
                    index_reg   <= bad_reg ? '0 : acc_reg + IDX_W'(prod_reg);
                    for (int a = 0; a < 3; a++)
                    begin
                        size_reg[a] <= bad_reg ? '0 : size_c[a];
                        last_reg[a] <= bad_reg ? 1'b0 : last_c[a];
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign brick_index    = index_reg;
    assign size_x         = size_reg[0];
    assign size_y         = size_reg[1];
    assign size_z         = size_reg[2];
    assign last_in_x      = last_reg[0];
    assign last_in_y      = last_reg[1];
    assign last_in_z      = last_reg[2];
    assign levels_present = present_reg;
    assign total_bricks   = total_reg;
    assign bad_request    = bad_out_reg;

endmodule
